// File: design/sectioned_slot_table_macros.svh
// Assertion macros shared by the checker of the sectioned slot table.
`ifndef SECTIONED_SLOT_TABLE_MACROS_SVH
`define SECTIONED_SLOT_TABLE_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define SST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sectioned_slot_table check failed");

// next-cycle implication, sampled on aclk, off during reset
`define SST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sectioned_slot_table check failed");

`endif

// File: design/sst_pkg.sv
// Shared types and constants of the sectioned slot table.
package sst_pkg;

    localparam int CMD_W       = 2;
    localparam int SECTION_W   = 3;
    localparam int OBJ_W       = 32;
    localparam int SLOT_W      = 9;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;
    localparam int M_PAD_W     = M_TDATA_W - SLOT_W - 1 - STATUS_W;

    localparam int DEF_SLOTS_PER_SECTION = 512;
    localparam int DEF_NUM_SECTIONS      = 8;
    localparam int DEF_ID_WIDTH          = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_RMALL  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_OOR  = 2'd2
    } status_t;

    // request token travelling down the cell chain
    typedef struct packed {
        logic                 vld;
        cmd_t                 cmd;
        logic [SECTION_W-1:0] section;
        logic [OBJ_W-1:0]     object_id;
    } tok_t;

    // per-cell status and result toward the top level
    typedef struct packed {
        logic              busy;
        logic              full;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } cres_t;

endpackage

// File: design/sectioned_slot_table.sv
// Sectioned slot table: top level with request intake, cell chain and result register.
//
// One cell per section, chained: a request enters cell 0 and moves one cell per
// cycle; the addressed cell (every cell for remove-from-all) takes it and walks its
// own id/in-use memories one slot per cycle, with registered memory reads.
// One request is in work at a time. How long it takes depends on F, the fill
// count of the section walked:
// add stops at the first free slot (at most F+1 reads), lookup at the first match,
// remove reads all F filled slots, remove-from-all the largest F of any section.
// A bad section number answers in the cycle after it is accepted. In-use bits at
// or above the fill count are treated as clear, so no memory clearing is needed
// after reset.
module sectioned_slot_table #(
    parameter int SLOTS_PER_SECTION = sst_pkg::DEF_SLOTS_PER_SECTION,
    parameter int NUM_SECTIONS      = sst_pkg::DEF_NUM_SECTIONS,
    parameter int ID_WIDTH          = sst_pkg::DEF_ID_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: command[1:0], section[4:2], object_id[36:5], zeros[39:37]
    input  logic [sst_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: slot_index[8:0], found[9], status[11:10], zeros[15:12]
    output logic [sst_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_OUT  = 3'b100
    } tstate_t;

    tstate_t           state_reg, state_next;
    tok_t              inj_reg, inj_next;
    logic              seen_reg, seen_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              found_reg, found_next;
    status_t           status_reg, status_next;

    tok_t  tok_w [NUM_SECTIONS+1];
    cres_t res_w [NUM_SECTIONS];

    cmd_t                 in_cmd;
    logic [SECTION_W-1:0] in_sec;
    logic [OBJ_W-1:0]     in_obj;
    logic                 in_acc;

    logic              any_busy, any_full, any_found;
    logic [SLOT_W-1:0] any_slot;

    assign in_cmd = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_sec = s_tdata[CMD_W+SECTION_W-1:CMD_W];
    assign in_obj = s_tdata[CMD_W+SECTION_W+OBJ_W-1:CMD_W+SECTION_W];
    assign in_acc = s_tvalid && s_tready;

    assign tok_w[0] = inj_reg;

    for (genvar g = 0; g < NUM_SECTIONS; g++) begin : g_cell
        sst_cell #(
            .SLOTS    (SLOTS_PER_SECTION),
            .ID_WIDTH (ID_WIDTH),
            .CELL_IDX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_w[g]),
            .tok_out (tok_w[g+1]),
            .res     (res_w[g])
        );
    end

    // only the addressed cell reports a nonzero slot, so OR merges results
    always_comb begin
        any_busy  = 1'b0;
        any_full  = 1'b0;
        any_found = 1'b0;
        any_slot  = '0;
        for (int i = 0; i < NUM_SECTIONS; i++) begin
            any_busy  = any_busy  | res_w[i].busy;
            any_full  = any_full  | res_w[i].full;
            any_found = any_found | res_w[i].found;
            any_slot  = any_slot  | res_w[i].slot;
        end
    end

    always_comb begin
        state_next       = state_reg;
        inj_next         = inj_reg;
        inj_next.vld     = 1'b0;
        seen_next        = seen_reg;
        slot_next        = slot_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        case (state_reg)
            T_IDLE: begin
                if (in_acc) begin
                    if (in_cmd != CMD_RMALL && 32'(in_sec) >= NUM_SECTIONS) begin
                        state_next  = T_OUT;
                        slot_next   = '0;
                        found_next  = 1'b0;
                        status_next = ST_OOR;
                    end else begin
                        state_next         = T_RUN;
                        inj_next.vld       = 1'b1;
                        inj_next.cmd       = in_cmd;
                        inj_next.section   = in_sec;
                        inj_next.object_id = in_obj;
                        seen_next          = 1'b0;
                    end
                end
            end
            T_RUN: begin
                // token past the last cell: every addressed cell has started
                if (tok_w[NUM_SECTIONS].vld) begin
                    seen_next = 1'b1;
                end
                if (seen_reg && !any_busy) begin
                    state_next  = T_OUT;
                    slot_next   = any_slot;
                    found_next  = any_found;
                    status_next = any_full ? ST_FULL : ST_OK;
                end
            end
            T_OUT: begin
                if (m_tready) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            inj_reg.vld <= 1'b0;
            seen_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inj_reg.vld <= inj_next.vld;
            seen_reg    <= seen_next;
        end
        inj_reg.cmd       <= inj_next.cmd;
        inj_reg.section   <= inj_next.section;
        inj_reg.object_id <= inj_next.object_id;
        slot_reg          <= slot_next;
        found_reg         <= found_next;
        status_reg        <= status_next;
    end

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = (state_reg == T_OUT);
    assign m_tdata  = {{M_PAD_W{1'b0}}, status_reg, found_reg, slot_reg};

endmodule

// File: design/sst_cell.sv
// One section of the slot table: id and in-use memories, fill count, scan engine.
module sst_cell #(
    parameter int SLOTS    = 512,
    parameter int ID_WIDTH = 32,
    parameter int CELL_IDX = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  sst_pkg::tok_t tok_in,
    output sst_pkg::tok_t tok_out,
    output sst_pkg::cres_t res
);
    import sst_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_SCAN = 2'b10
    } cstate_t;

    logic [ID_WIDTH-1:0] id_mem  [SLOTS];
    logic                use_mem [SLOTS];

    cstate_t             state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [CW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [ID_WIDTH-1:0] id_q_reg;
    logic                use_q_reg;
    logic                full_reg, full_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    tok_t                tok_reg;

    logic          tgt, issue, live, in_use, match, hit, use_we, use_wdata, id_we;
    logic [CW-1:0] limit;

    assign tgt = tok_in.vld && (tok_in.cmd == CMD_RMALL || 32'(tok_in.section) == CELL_IDX);

    // add may stop one past the fill count: that slot is free by construction
    assign limit = (cmd_reg != CMD_ADD) ? fill_reg :
                   (fill_reg < SLOTS_C) ? fill_reg + CW'(1) : SLOTS_C;

    assign live   = {1'b0, rd_addr_reg} < fill_reg;
    assign in_use = use_q_reg && live;
    assign match  = live && (id_q_reg == id_reg);
    assign hit    = rd_vld_reg && ((cmd_reg == CMD_ADD && !in_use) ||
                                   (cmd_reg == CMD_LOOKUP && match));
    assign issue  = (state_reg == C_SCAN) && (addr_reg < limit) && !hit;

    assign id_we     = hit && (cmd_reg == CMD_ADD);
    assign use_wdata = (cmd_reg == CMD_ADD);
    assign use_we    = id_we || (rd_vld_reg && match &&
                                 (cmd_reg == CMD_REMOVE || cmd_reg == CMD_RMALL));

    always_ff @(posedge aclk) begin
        if (issue) begin
            id_q_reg  <= id_mem[addr_reg[AW-1:0]];
            use_q_reg <= use_mem[addr_reg[AW-1:0]];
        end
        if (id_we) begin
            id_mem[rd_addr_reg] <= id_reg;
        end
        if (use_we) begin
            use_mem[rd_addr_reg] <= use_wdata;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        addr_next    = issue ? addr_reg + CW'(1) : addr_reg;
        rd_vld_next  = issue;
        rd_addr_next = issue ? addr_reg[AW-1:0] : rd_addr_reg;
        fill_next    = fill_reg;
        full_next    = full_reg;
        found_next   = found_reg;
        slot_next    = slot_reg;
        case (state_reg)
            C_IDLE: begin
                if (tok_in.vld) begin
                    full_next  = 1'b0;
                    found_next = 1'b0;
                    slot_next  = '0;
                end
                if (tgt) begin
                    state_next  = C_SCAN;
                    cmd_next    = tok_in.cmd;
                    id_next     = ID_WIDTH'(tok_in.object_id);
                    addr_next   = '0;
                    rd_vld_next = 1'b0;
                end
            end
            C_SCAN: begin
                if (hit) begin
                    state_next = C_IDLE;
                    slot_next  = SLOT_W'(rd_addr_reg);
                    found_next = (cmd_reg == CMD_LOOKUP);
                    if (cmd_reg == CMD_ADD && !live) begin
                        fill_next = {1'b0, rd_addr_reg} + CW'(1);
                    end
                end else if (!issue && !rd_vld_reg) begin
                    state_next = C_IDLE;
                    full_next  = (cmd_reg == CMD_ADD);
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            full_reg    <= 1'b0;
            found_reg   <= 1'b0;
            slot_reg    <= '0;
            tok_reg.vld <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= rd_vld_next;
            full_reg    <= full_next;
            found_reg   <= found_next;
            slot_reg    <= slot_next;
            tok_reg.vld <= tok_in.vld;
        end
        tok_reg.cmd       <= tok_in.cmd;
        tok_reg.section   <= tok_in.section;
        tok_reg.object_id <= tok_in.object_id;
        cmd_reg           <= cmd_next;
        id_reg            <= id_next;
        addr_reg          <= addr_next;
        rd_addr_reg       <= rd_addr_next;
    end

    assign tok_out   = tok_reg;
    assign res.busy  = (state_reg == C_SCAN);
    assign res.full  = full_reg;
    assign res.found = found_reg;
    assign res.slot  = slot_reg;

endmodule

// File: design/sst_checker.sv
// Port-level checker for the sectioned slot table, with its bind.
`include "sectioned_slot_table_macros.svh"

module sst_checker #(
    parameter int NUM_SECTIONS = sst_pkg::DEF_NUM_SECTIONS
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [sst_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sst_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import sst_pkg::*;

    logic bad_sec_req;
    assign bad_sec_req = s_tvalid && s_tready && (s_tdata[1:0] != CMD_RMALL) &&
                         (32'(s_tdata[4:2]) >= NUM_SECTIONS);

    `SST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata))
    `SST_ASSERT_NOW(a_one_in_work, s_tvalid && s_tready, !m_tvalid)
    `SST_ASSERT_NOW(a_found_ok, m_tvalid && m_tdata[9], m_tdata[11:10] == ST_OK)
    `SST_ASSERT_NEXT(a_bad_section, bad_sec_req, m_tvalid && m_tdata[11:10] == ST_OOR)

endmodule

bind sectioned_slot_table sst_checker #(.NUM_SECTIONS(NUM_SECTIONS)) u_sst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
